/* rtl/upload_path_safety_checker_defines.svh */
// Assertion macros for the upload path safety checker's checker module.
`ifndef UPLOAD_PATH_SAFETY_CHECKER_DEFINES_SVH
`define UPLOAD_PATH_SAFETY_CHECKER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define UPC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upload path checker: assertion failed");

// Next-cycle implication, switched off while reset is high.
`define UPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upload path checker: assertion failed");

// Next-cycle implication that also holds through reset.
`define UPC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("upload path checker: assertion failed");

`endif

/* rtl/upc_pkg.sv */
// Types, constants and prefix tables of the upload path safety checker.
package upc_pkg;

  // Verdict codes, in the order in which the checks are applied.
  typedef enum logic [2:0] {
    REASON_OK       = 3'd0,
    REASON_EMPTY    = 3'd1,
    REASON_TOO_LONG = 3'd2,
    REASON_CONTROL  = 3'd3,
    REASON_SLASHES  = 3'd4,
    REASON_DOTS     = 3'd5,
    REASON_PREFIX   = 3'd6
  } reason_t;

  typedef struct packed {
    logic    safe;
    reason_t reason;
  } verdict_t;

  // Registered path byte handed from the input stage to the scanner.
  typedef struct packed {
    logic       fire;
    logic [7:0] data;
  } byte_xfer_t;

  localparam int unsigned ASSETS_LEN = 8;
  localparam int unsigned FONTS_LEN  = 7;

  localparam logic [7:0] TERMINATOR   = 8'h00;
  localparam logic [7:0] CONTROL_LAST = 8'h1F;
  localparam logic [7:0] DEL_CHAR     = 8'h7F;
  localparam logic [7:0] SLASH_CHAR   = 8'h2F;
  localparam logic [7:0] DOT_CHAR     = 8'h2E;

  // Characters of "/assets/".
  function automatic logic [7:0] assets_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "/";
      3'd1:    c = "a";
      3'd2:    c = "s";
      3'd3:    c = "s";
      3'd4:    c = "e";
      3'd5:    c = "t";
      3'd6:    c = "s";
      default: c = "/";
    endcase
    return c;
  endfunction

  // Characters of "/fonts/"; the last index is never used.
  function automatic logic [7:0] fonts_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "/";
      3'd1:    c = "f";
      3'd2:    c = "o";
      3'd3:    c = "n";
      3'd4:    c = "t";
      3'd5:    c = "s";
      3'd6:    c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/upc_input_stage.sv */
// Input register that holds one path byte and hands it to the scanner.
module upc_input_stage import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       out_room,
  output byte_xfer_t item
);

  logic       held;
  logic [7:0] held_byte;
  logic       advance;

  // A plain byte always moves on; a terminator needs a free result slot.
  assign advance  = held && ((held_byte != TERMINATOR) || out_room);
  assign s_tready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tready) begin
      held <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_byte <= s_tdata;
    end
  end

  assign item.fire  = advance;
  assign item.data  = held_byte;

endmodule

/* rtl/upc_scanner.sv */
// Per-path state: length, previous byte, hazard flags and prefix matches.
module upc_scanner import upc_pkg::*; #(
  parameter int unsigned MAX_PATH_LEN = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  byte_xfer_t item,
  output logic       verdict_load,
  output verdict_t   verdict
);

  localparam int unsigned CW = $clog2(MAX_PATH_LEN + 1);
  localparam logic [CW-1:0] MAX_CNT    = CW'(MAX_PATH_LEN);
  localparam logic [CW-1:0] ASSETS_CNT = CW'(ASSETS_LEN);
  localparam logic [CW-1:0] FONTS_CNT  = CW'(FONTS_LEN);

  logic [CW-1:0] char_count, char_count_next;
  logic [7:0]    prior_byte, prior_byte_next;
  logic          control_seen, control_seen_next;
  logic          slash_pair_seen, slash_pair_seen_next;
  logic          dot_pair_seen, dot_pair_seen_next;
  logic          assets_prefix_alive, assets_prefix_alive_next;
  logic          fonts_prefix_alive, fonts_prefix_alive_next;

  logic [7:0] c;
  logic       is_term;
  reason_t    reason;

  assign c       = item.data;
  assign is_term = (c == TERMINATOR);

  // State update for one non-zero byte; the terminator returns to reset.
  always_comb begin
    char_count_next          = char_count;
    prior_byte_next          = prior_byte;
    control_seen_next        = control_seen;
    slash_pair_seen_next     = slash_pair_seen;
    dot_pair_seen_next       = dot_pair_seen;
    assets_prefix_alive_next = assets_prefix_alive;
    fonts_prefix_alive_next  = fonts_prefix_alive;
    if (item.fire) begin
      if (is_term) begin
        char_count_next          = '0;
        prior_byte_next          = 8'h00;
        control_seen_next        = 1'b0;
        slash_pair_seen_next     = 1'b0;
        dot_pair_seen_next       = 1'b0;
        assets_prefix_alive_next = 1'b1;
        fonts_prefix_alive_next  = 1'b1;
      end else begin
        if ((c <= CONTROL_LAST) || (c == DEL_CHAR)) begin
          control_seen_next = 1'b1;
        end
        if ((c == SLASH_CHAR) && (prior_byte == SLASH_CHAR)) begin
          slash_pair_seen_next = 1'b1;
        end
        if ((c == DOT_CHAR) && (prior_byte == DOT_CHAR)) begin
          dot_pair_seen_next = 1'b1;
        end
        if ((char_count < ASSETS_CNT) && (c != assets_char(char_count[2:0]))) begin
          assets_prefix_alive_next = 1'b0;
        end
        if ((char_count < FONTS_CNT) && (c != fonts_char(char_count[2:0]))) begin
          fonts_prefix_alive_next = 1'b0;
        end
        if (char_count < MAX_CNT) begin
          char_count_next = char_count + 1'b1;
        end
        prior_byte_next = c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count          <= '0;
      prior_byte          <= 8'h00;
      control_seen        <= 1'b0;
      slash_pair_seen     <= 1'b0;
      dot_pair_seen       <= 1'b0;
      assets_prefix_alive <= 1'b1;
      fonts_prefix_alive  <= 1'b1;
    end else begin
      char_count          <= char_count_next;
      prior_byte          <= prior_byte_next;
      control_seen        <= control_seen_next;
      slash_pair_seen     <= slash_pair_seen_next;
      dot_pair_seen       <= dot_pair_seen_next;
      assets_prefix_alive <= assets_prefix_alive_next;
      fonts_prefix_alive  <= fonts_prefix_alive_next;
    end
  end

  // Verdict priority: the first failing check wins.
  always_comb begin
    if (char_count == '0) begin
      reason = REASON_EMPTY;
    end else if (char_count >= MAX_CNT) begin
      reason = REASON_TOO_LONG;
    end else if (control_seen) begin
      reason = REASON_CONTROL;
    end else if (slash_pair_seen) begin
      reason = REASON_SLASHES;
    end else if (dot_pair_seen) begin
      reason = REASON_DOTS;
    end else if (assets_prefix_alive && (char_count > ASSETS_CNT)) begin
      reason = REASON_OK;
    end else if (fonts_prefix_alive && (char_count > FONTS_CNT)) begin
      reason = REASON_OK;
    end else begin
      reason = REASON_PREFIX;
    end
  end

  assign verdict_load   = item.fire && is_term;
  assign verdict.safe   = (reason == REASON_OK);
  assign verdict.reason = reason;

endmodule

/* rtl/upc_result_reg.sv */
// Result register that holds one verdict until the downstream side takes it.
module upc_result_reg import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  verdict_t   verdict,
  output logic       room,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata
);

  verdict_t held;

  // The slot is free when empty or when its transaction completes now.
  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= verdict;
    end
  end

  assign m_tdata = {4'b0000, held.reason, held.safe};

endmodule

/* rtl/upload_path_safety_checker.sv */
// Top level of the upload path safety checker.
// Takes a file path one byte per transaction; a zero byte ends the path and
// yields one verdict transaction, other bytes yield none. The block accepts a
// byte in every cycle unless a terminator waits for a free result slot. A
// verdict is formed from the per-path state registers and loaded into the
// result register; a terminator waits in the input register only while an
// earlier verdict is still not taken. The verdict reports the first failing
// check in order: empty, too long (MAX_PATH_LEN bytes or more), control or
// DEL byte, double slash, double dot, no "/assets/" or "/fonts/" prefix with
// at least one byte after it. State returns to reset after each verdict.
module upload_path_safety_checker import upc_pkg::*; #(
  parameter int unsigned MAX_PATH_LEN = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] path_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] safe, [3:1] fail_reason, [7:4] zero
);

  byte_xfer_t item;
  logic       out_room;
  logic       verdict_load;
  verdict_t   verdict;

  upc_input_stage u_input (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .out_room (out_room),
    .item     (item)
  );

  upc_scanner #(
    .MAX_PATH_LEN (MAX_PATH_LEN)
  ) u_scanner (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .verdict_load (verdict_load),
    .verdict      (verdict)
  );

  upc_result_reg u_result (
    .clk      (clk),
    .rst      (rst),
    .load     (verdict_load),
    .verdict  (verdict),
    .room     (out_room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* rtl/upc_checker.sv */
// Port-level assertions for the upload path safety checker, bound to the top.
`include "upload_path_safety_checker_defines.svh"

module upc_checker import upc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  logic byte_in;
  logic code_ok;

  // A non-zero path byte taken on the input side.
  assign byte_in = s_tvalid && s_tready && (s_tdata != TERMINATOR);

  // The safe flag agrees with the reason code, and padding is zero.
  assign code_ok = (m_tdata[0] == (m_tdata[3:1] == REASON_OK)) && (m_tdata[7:4] == 4'd0);

  // A stalled verdict stays presented.
  `UPC_ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  // A presented verdict is well formed.
  `UPC_ASSERT_IMPL(a_safe_code, clk, rst, m_tvalid, code_ok)
  // Reason codes stay within the defined set.
  `UPC_ASSERT_IMPL(a_reason_range, clk, rst, m_tvalid, m_tdata[3:1] <= REASON_PREFIX)
  // A plain byte never blocks the input in the following cycle.
  `UPC_ASSERT_NEXT(a_byte_ready, clk, rst, byte_in, s_tready)
  // Reset empties the result register.
  `UPC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid)

endmodule

bind upload_path_safety_checker upc_checker u_upc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/upload_path_safety_checker_tb.sv */
// Self-checking testbench that streams paths into the upload path safety checker and checks verdicts.
`timescale 1ns / 1ps

module upload_path_safety_checker_tb;
  import upc_pkg::*;

  localparam int unsigned PATH_LIMIT = 128;
  localparam int unsigned RANDOM_BYTES = 300;
  localparam int unsigned MAX_REPORTS = 10;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;

  // Scanner state of the path that is in flight on the input side.
  int unsigned path_len;
  logic [7:0]  prev_byte;
  bit          ctrl_hit;
  bit          slash_hit;
  bit          dot_hit;
  bit          assets_ok;
  bit          fonts_ok;

  // Verdicts still owed by the block, oldest first.
  verdict_t    pending_verdicts[$];

  // Path being assembled before it is streamed in.
  logic [7:0]  path_buf[$];

  logic [7:0]  assets_ref [8] = '{"/", "a", "s", "s", "e", "t", "s", "/"};
  logic [7:0]  fonts_ref  [7] = '{"/", "f", "o", "n", "t", "s", "/"};
  string       body_chars = "abcdefghijklmnopqrstuvwxyz0123456789-_";

  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned paths_sent;
  int unsigned reason_hits [7];
  bit          steady_send;
  bit          steady_ready;
  int unsigned stall_left;

  upload_path_safety_checker #(
    .MAX_PATH_LEN(PATH_LIMIT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Gap length: mostly short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_body_char();
    int unsigned p;
    p = $urandom_range(0, 19);
    if (p == 0) return SLASH_CHAR;
    if (p == 1) return DOT_CHAR;
    return body_chars[$urandom_range(0, body_chars.len() - 1)];
  endfunction

  // Advance the path scanner by one accepted byte; a terminator yields a verdict.
  task automatic scan_path_byte(input logic [7:0] b);
    verdict_t v;
    reason_t  r;
    if (b == TERMINATOR) begin
      if (path_len == 0) r = REASON_EMPTY;
      else if (path_len >= PATH_LIMIT) r = REASON_TOO_LONG;
      else if (ctrl_hit) r = REASON_CONTROL;
      else if (slash_hit) r = REASON_SLASHES;
      else if (dot_hit) r = REASON_DOTS;
      else if ((assets_ok && path_len > ASSETS_LEN) || (fonts_ok && path_len > FONTS_LEN))
        r = REASON_OK;
      else r = REASON_PREFIX;
      v.safe   = (r == REASON_OK);
      v.reason = r;
      pending_verdicts.push_back(v);
      path_len  = 0;
      prev_byte = 8'h00;
      ctrl_hit  = 1'b0;
      slash_hit = 1'b0;
      dot_hit   = 1'b0;
      assets_ok = 1'b1;
      fonts_ok  = 1'b1;
    end else begin
      if (b <= CONTROL_LAST || b == DEL_CHAR) ctrl_hit = 1'b1;
      if (b == SLASH_CHAR && prev_byte == SLASH_CHAR) slash_hit = 1'b1;
      if (b == DOT_CHAR && prev_byte == DOT_CHAR) dot_hit = 1'b1;
      if (path_len < ASSETS_LEN && b != assets_ref[path_len]) assets_ok = 1'b0;
      if (path_len < FONTS_LEN && b != fonts_ref[path_len]) fonts_ok = 1'b0;
      if (path_len < PATH_LIMIT) path_len++;
      prev_byte = b;
    end
  endtask

  // Send one byte, with an optional idle gap first, and wait for its transaction.
  task automatic push_path_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (!steady_send && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = b;
    do @(posedge clk); while (!s_tready);
    scan_path_byte(b);
    bytes_sent++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) path_buf.push_back(s[i]);
  endtask

  task automatic add_body(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) path_buf.push_back(rand_body_char());
  endtask

  // Stream the assembled path followed by its terminator.
  task automatic send_path_buf();
    foreach (path_buf[i]) push_path_byte(path_buf[i]);
    push_path_byte(TERMINATOR);
    paths_sent++;
  endtask

  task automatic send_text(input string s);
    path_buf.delete();
    add_text(s);
    send_path_buf();
  endtask

  // Text followed by one raw byte and a short tail.
  task automatic send_with_byte(input string head, input logic [7:0] b, input string tail);
    path_buf.delete();
    add_text(head);
    path_buf.push_back(b);
    add_text(tail);
    send_path_buf();
  endtask

  // Release the input and hold off until every owed verdict has come back.
  task automatic wait_for_verdicts();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Compare each verdict transaction with the oldest owed verdict.
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected verdict transaction: tdata=%02h", $time, m_tdata);
      end else begin
        exp_v = pending_verdicts.pop_front();
        reason_hits[exp_v.reason]++;
        if (m_tdata[0] !== exp_v.safe || m_tdata[3:1] !== exp_v.reason ||
            m_tdata[7:4] !== 4'h0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("[%0t] verdict mismatch: expected safe=%0b reason=%s, got tdata=%02h",
                     $time, exp_v.safe, exp_v.reason.name(), m_tdata);
        end
      end
    end
  end

  // Receiver side: ready with random stalls, or steadily ready for a stretch.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else begin
      m_tready = 1'b1;
      if (!steady_ready && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Extremes of the byte, each check alone, check order, and the short and first-byte cases.
  task automatic test_directed_paths();
    send_text("");
    send_text("/assets/a");
    send_text("/fonts/b");
    send_text("/assets/");
    send_text("/fonts/");
    send_text("/fonts");
    send_text("/assetsX/z");
    send_text("/fonts/x/y.png");
    send_text("//fonts/a");
    send_text("/assets/a..b");
    send_text("../x");
    send_text(".a");
    send_text("/assets/./x");
    send_with_byte("/assets/a", 8'h01, "b");
    send_with_byte("/assets/a", CONTROL_LAST, "");
    send_with_byte("/fonts/a", DEL_CHAR, "");
    send_with_byte("/fonts/a", 8'h20, "z");
    send_with_byte("/fonts/", 8'hFF, "");
    send_with_byte("/assets/", 8'h80, "q");
    send_with_byte("//a", 8'h7F, "..");
    send_text("/fonts/a//b..c");
  endtask

  // Paths around the length limit, including one long enough to saturate the count.
  task automatic test_length_limit();
    int unsigned lens [4] = '{PATH_LIMIT - 1, PATH_LIMIT, PATH_LIMIT + 1, 160};
    foreach (lens[i]) begin
      path_buf.delete();
      add_text("/assets/");
      while (path_buf.size() < lens[i]) path_buf.push_back("k");
      if (i == 3) path_buf[20] = 8'h05;
      send_path_buf();
    end
  endtask

  // Hold the sender off until the block has returned every verdict, then resume.
  task automatic test_drain_pause();
    steady_ready = 1'b0;
    send_text("/fonts/a");
    send_text("/assets/bb");
    wait_for_verdicts();
    send_text("/fonts/ok");
    steady_send = 1'b1;
    steady_ready = 1'b1;
    send_text("/assets/tight");
    send_text("");
    send_text("/fonts/x");
    steady_send = 1'b0;
    steady_ready = 1'b0;
  endtask

  // Mostly well-formed paths with random bodies, plus faults, broken prefixes and noise.
  task automatic test_random_paths();
    int unsigned kind;
    int unsigned start;
    int unsigned cut;
    int unsigned pos;
    logic [7:0]  fault;
    start = bytes_sent;
    while (bytes_sent < start + RANDOM_BYTES) begin
      path_buf.delete();
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        add_text($urandom_range(0, 1) ? "/assets/" : "/fonts/");
        add_body($urandom_range(0, 14));
        if (kind >= 11) begin
          pos = $urandom_range(0, path_buf.size());
          case ($urandom_range(0, 2))
            0: begin
              fault = $urandom_range(0, 4) == 0 ? DEL_CHAR : 8'($urandom_range(1, 31));
              path_buf.insert(pos, fault);
            end
            1: begin
              path_buf.insert(pos, SLASH_CHAR);
              path_buf.insert(pos, SLASH_CHAR);
            end
            default: begin
              path_buf.insert(pos, DOT_CHAR);
              path_buf.insert(pos, DOT_CHAR);
            end
          endcase
        end
      end else if (kind < 16) begin
        // Prefix cut short or with one character changed.
        add_text($urandom_range(0, 1) ? "/assets/" : "/fonts/");
        cut = $urandom_range(0, path_buf.size());
        while (path_buf.size() > cut) void'(path_buf.pop_back());
        if (path_buf.size() != 0 && $urandom_range(0, 1) == 0)
          path_buf[$urandom_range(0, path_buf.size() - 1)] = rand_body_char();
        add_body($urandom_range(0, 6));
      end else if (kind < 19) begin
        repeat ($urandom_range(0, 10)) path_buf.push_back(8'($urandom_range(1, 255)));
      end else begin
        add_text("/fonts/");
        if ($urandom_range(0, 4) == 0) cut = $urandom_range(140, 260);
        else cut = $urandom_range(PATH_LIMIT - 3, PATH_LIMIT + 3);
        while (path_buf.size() < cut) path_buf.push_back(rand_body_char());
      end
      if ($urandom_range(0, 9) == 0) steady_send = !steady_send;
      if ($urandom_range(0, 9) == 0) steady_ready = !steady_ready;
      send_path_buf();
      if ($urandom_range(0, 49) == 0) wait_for_verdicts();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    m_tready = 1'b0;
    stall_left = 0;
    steady_send = 1'b0;
    steady_ready = 1'b0;
    errors = 0;
    bytes_sent = 0;
    paths_sent = 0;
    path_len = 0;
    prev_byte = 8'h00;
    ctrl_hit = 1'b0;
    slash_hit = 1'b0;
    dot_hit = 1'b0;
    assets_ok = 1'b1;
    fonts_ok = 1'b1;
    foreach (reason_hits[i]) reason_hits[i] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_paths();
    test_length_limit();
    test_drain_pause();
    test_random_paths();

    wait_for_verdicts();
    repeat (8) @(posedge clk);

    $display("Streamed %0d bytes in %0d paths with random gaps and stalls on both sides.",
             bytes_sent, paths_sent);
    $write("Verdicts by reason: ok %0d, empty %0d, too long %0d, control %0d, ",
           reason_hits[REASON_OK], reason_hits[REASON_EMPTY], reason_hits[REASON_TOO_LONG],
           reason_hits[REASON_CONTROL]);
    $display("slashes %0d, dots %0d, prefix %0d; mismatches %0d.",
             reason_hits[REASON_SLASHES], reason_hits[REASON_DOTS],
             reason_hits[REASON_PREFIX], errors);
    if (errors == 0) begin
      $display("upload_path_safety_checker verification clean");
    end else begin
      $display("upload_path_safety_checker verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Timeout with %0d verdicts still owed.", pending_verdicts.size());
    $display("upload_path_safety_checker verification failed");
    $finish;
  end

endmodule
